### hdl/luby_restart_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Luby restart scheduler assertion macros
// Clocked, reset-qualified property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef LUBY_RESTART_SCHEDULER_ASSERT_SVH
`define LUBY_RESTART_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define LRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// Luby restart scheduler package
// Shared widths, the unit reset value and state encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

    localparam int LRS_INDEX_BITS = 32;
    localparam int LRS_COUNT_W    = 48;
    localparam int LRS_UNIT_W     = 16;
    localparam int LRS_TOTAL_W    = 32;
    localparam int LRS_LIMIT_W    = LRS_COUNT_W + 1;

    localparam logic [LRS_UNIT_W-1:0] LRS_UNIT_RESET = LRS_UNIT_W'(100);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LUBY,
        S_SHIFT,
        S_UPDATE,
        S_DONE
    } lrs_state_t;

    typedef enum logic [1:0] {
        L_IDLE,
        L_GROW,
        L_REDUCE
    } lrs_luby_state_t;

endpackage

`default_nettype wire

### hdl/lrs_luby_unit.sv
// ----------------------------------------------------------------------------
// Luby exponent unit
// Finds seq with luby(idx) = 2^seq using one compare/subtract per cycle:
// a growth phase over the block sizes, then a reduction phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrs_luby_unit #(
    parameter int INDEX_BITS = 32,
    parameter int SEQ_W      = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [INDEX_BITS-1:0] idx,
    output logic                       done,
    output logic [SEQ_W-1:0]           seq
);
    import lrs_pkg::*;

    lrs_luby_state_t state_reg, state_next;

    logic [INDEX_BITS:0]   span_reg, span_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;

    logic                  grow_more;
    logic                  reduce_hit;
    logic [INDEX_BITS:0]   span_half;
    logic                  idx_ge;

    assign grow_more  = span_reg <= {1'b0, idx_reg};
    assign reduce_hit = {span_reg[INDEX_BITS:1], 1'b0} == {1'b0, idx_reg};
    assign span_half  = {1'b0, span_reg[INDEX_BITS:1]};
    assign idx_ge     = {1'b0, idx_reg} >= span_half;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                    state_next = L_GROW;
            end
            L_GROW:
            begin
                if (!grow_more)
                    state_next = L_REDUCE;
            end
            L_REDUCE:
            begin
                if (reduce_hit)
                    state_next = L_IDLE;
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_comb
    begin
        span_next = span_reg;
        idx_next  = idx_reg;
        seq_next  = seq_reg;
        done      = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    span_next = (INDEX_BITS+1)'(1);
                    idx_next  = idx;
                    seq_next  = '0;
                end
            end
            L_GROW:
            begin
                if (grow_more)
                begin
                    span_next = {span_reg[INDEX_BITS-1:0], 1'b1};
                    seq_next  = seq_reg + SEQ_W'(1);
                end
            end
            L_REDUCE:
            begin
                if (reduce_hit)
                    done = 1'b1;
                else
                begin
                    span_next = span_half;
                    seq_next  = seq_reg - SEQ_W'(1);
                    if (idx_ge)
                        idx_next = idx_reg - span_half[INDEX_BITS-1:0];
                end
            end
            default: done = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= L_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        idx_reg  <= idx_next;
        seq_reg  <= seq_next;
    end

    assign seq = seq_reg;

endmodule

`default_nettype wire

### hdl/luby_restart_scheduler.sv
// Without a restart a beat goes S_CHECK, S_DONE; with one S_CHECK, S_LUBY (grow +
//   reduce steps of the Luby unit, one compare/subtract step per cycle), S_SHIFT,
//   S_UPDATE, S_DONE. The result is registered out of S_DONE once the slot is free.
// One item at a time: in_ready is high only in S_IDLE, so a new input beat waits
//   until the last result is loaded, and longer while that result beat is stalled.
// Reset: limit, restart index and total clear to zero; restart_unit returns to 100.
// ----------------------------------------------------------------------------
// Luby restart scheduler
// Signals a restart when the conflict count passes the limit and sets the
// next limit from the Luby sequence scaled by restart_unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module luby_restart_scheduler #(
    parameter int INDEX_BITS = lrs_pkg::LRS_INDEX_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lrs_pkg::LRS_UNIT_W-1:0]    cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [lrs_pkg::LRS_COUNT_W-1:0]   conflict_count,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   restart,
    output logic [lrs_pkg::LRS_TOTAL_W-1:0]        restart_total
);
    import lrs_pkg::*;

    localparam int SEQ_W = $clog2(INDEX_BITS + 1);
    localparam int GAP_W = LRS_UNIT_W + INDEX_BITS;

    lrs_state_t state_reg, state_next;

    logic [LRS_UNIT_W-1:0]  unit_reg;
    logic [LRS_COUNT_W-1:0] count_reg;
    logic [LRS_LIMIT_W-1:0] limit_reg;
    logic [INDEX_BITS-1:0]  index_reg;
    logic [LRS_TOTAL_W-1:0] total_reg;
    logic                   fire_reg;
    logic [GAP_W-1:0]       gap_reg;
    logic                   out_valid_reg;
    logic                   restart_reg;
    logic [LRS_TOTAL_W-1:0] restart_total_reg;

    logic                   fire;
    logic                   luby_start;
    logic                   luby_done;
    logic [SEQ_W-1:0]       luby_seq;
    logic                   slot_free;
    logic                   accept;
    logic                   load_out;
    logic                   do_update;

    assign fire      = {1'b0, count_reg} > limit_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    lrs_luby_unit #(
        .INDEX_BITS (INDEX_BITS),
        .SEQ_W      (SEQ_W)
    ) u_luby (
        .clk   (clk),
        .rst_n (rst_n),
        .start (luby_start),
        .idx   (index_reg),
        .done  (luby_done),
        .seq   (luby_seq)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:  state_next = fire ? S_LUBY : S_DONE;
            S_LUBY:
            begin
                if (luby_done)
                    state_next = S_SHIFT;
            end
            S_SHIFT:  state_next = S_UPDATE;
            S_UPDATE: state_next = S_DONE;
            S_DONE:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        luby_start = 1'b0;
        do_update  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready   = 1'b1;
            S_CHECK:  luby_start = fire;
            S_LUBY:   in_ready   = 1'b0;
            S_SHIFT:  in_ready   = 1'b0;
            S_UPDATE: do_update  = 1'b1;
            S_DONE:   load_out   = slot_free;
            default:  in_ready   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            unit_reg      <= LRS_UNIT_RESET;
            limit_reg     <= '0;
            index_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                unit_reg <= cfg_wr_data;
            if (do_update)
            begin
                limit_reg <= {1'b0, count_reg} + LRS_LIMIT_W'(gap_reg);
                if (index_reg != '1)
                    index_reg <= index_reg + INDEX_BITS'(1);
                if (total_reg != '1)
                    total_reg <= total_reg + LRS_TOTAL_W'(1);
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            count_reg <= conflict_count;
        if (state_reg == S_CHECK)
            fire_reg <= fire;
        if (state_reg == S_SHIFT)
            gap_reg <= GAP_W'(unit_reg) << luby_seq;
        if (load_out)
        begin
            restart_reg       <= fire_reg;
            restart_total_reg <= total_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign restart       = restart_reg;
    assign restart_total = restart_total_reg;

endmodule

`default_nettype wire

### hdl/lrs_checker.sv
// ----------------------------------------------------------------------------
// Luby restart scheduler port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "luby_restart_scheduler_assert.svh"

module lrs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic                              restart,
    input wire logic [lrs_pkg::LRS_TOTAL_W-1:0]   restart_total
);

    // one item in flight: busy right after an input beat
    `LRS_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after input beat")

    // a restart beat always carries a nonzero total
    `LRS_ASSERT_IMP(a_total_nonzero, out_valid && restart, restart_total != '0, "restart with zero total")

    // stalled result holds
    `LRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(restart) && $stable(restart_total), "stalled result changed")

endmodule

bind luby_restart_scheduler lrs_checker u_lrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .restart       (restart),
    .restart_total (restart_total)
);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// Luby restart scheduler testbench
// Sends conflict counts around the running limit and compares each result
// beat with a local predictor: restart flag and running restart total.
// Also covers step-size changes between phases, random stalls on both
// sides and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class luby_scoreboard;
    bit [lrs_pkg::LRS_UNIT_W-1:0]      step_size;
    bit [63:0]                         threshold;
    bit [lrs_pkg::LRS_INDEX_BITS-1:0]  luby_pos;
    bit [lrs_pkg::LRS_TOTAL_W-1:0]     fired_total;
    bit                                exp_fire_q[$];
    bit [lrs_pkg::LRS_TOTAL_W-1:0]     exp_total_q[$];
    int unsigned                       errors;

    function new();
        step_size   = lrs_pkg::LRS_UNIT_RESET;
        threshold   = '0;
        luby_pos    = '0;
        fired_total = '0;
        errors      = 0;
    endfunction

    function void set_step(bit [lrs_pkg::LRS_UNIT_W-1:0] v);
        step_size = v;
    endfunction

    function int pending();
        return exp_fire_q.size();
    endfunction

    // exponent of the Luby term at position pos
    function int unsigned luby_power(bit [63:0] pos);
        bit [63:0]   span;
        int unsigned pw;
        span = 64'd1;
        pw   = 0;
        while (span < pos + 64'd1)
        begin
            span = 64'd2 * span + 64'd1;
            pw++;
        end
        while (span - 64'd1 != pos)
        begin
            span = (span - 64'd1) >> 1;
            pw--;
            pos  = pos % span;
        end
        return pw;
    endfunction

    function void note_count(bit [lrs_pkg::LRS_COUNT_W-1:0] cnt);
        bit        fire;
        bit [63:0] cnt64;
        bit [63:0] term;
        bit [63:0] gap;
        fire  = 1'b0;
        cnt64 = 64'(cnt);
        if (cnt64 > threshold)
        begin
            term = 64'd1 << luby_power(64'(luby_pos));
            gap  = term * 64'(step_size);
            if (gap > ~64'd0 - cnt64)
                threshold = '1;
            else
                threshold = cnt64 + gap;
            if (luby_pos != '1)
                luby_pos++;
            if (fired_total != '1)
                fired_total++;
            fire = 1'b1;
        end
        exp_fire_q.push_back(fire);
        exp_total_q.push_back(fired_total);
    endfunction

    function void check_result(logic fire, logic [lrs_pkg::LRS_TOTAL_W-1:0] total);
        bit                            e_fire;
        bit [lrs_pkg::LRS_TOTAL_W-1:0] e_total;
        if (exp_fire_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result beat: restart=%0b total=%0d", fire, total);
            return;
        end
        e_fire  = exp_fire_q.pop_front();
        e_total = exp_total_q.pop_front();
        if (fire !== e_fire || total !== e_total)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected restart=%0b total=%0d, got restart=%0b total=%0d",
                         e_fire, e_total, fire, total);
        end
    endfunction
endclass

module tb;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [lrs_pkg::LRS_UNIT_W-1:0]    cfg_wr_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [lrs_pkg::LRS_COUNT_W-1:0]   conflict_count;
    logic                              out_valid;
    logic                              out_ready;
    logic                              restart;
    logic [lrs_pkg::LRS_TOTAL_W-1:0]   restart_total;

    luby_scoreboard sb = new();
    int unsigned    n_sent;
    int unsigned    n_taken;

    luby_restart_scheduler u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .conflict_count (conflict_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .restart        (restart),
        .restart_total  (restart_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL luby_restart_scheduler");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(restart, restart_total);
    end

    // result side: random stalls, quiet stretches, one long hold-off
    initial
    begin
        int unsigned w;
        bit          held;
        out_ready = 1'b0;
        n_taken   = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            w = ((n_taken / 70) % 3 == 2) ? 0 : $urandom_range(0, 18);
            if (!held && n_taken == 500)
            begin
                w    = 300;
                held = 1'b1;
            end
            if (w != 0)
            begin
                out_ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            n_taken++;
            @(negedge clk);
        end
    end

    task automatic send_count(input logic [lrs_pkg::LRS_COUNT_W-1:0] cnt);
        int unsigned gap;
        in_valid       <= 1'b1;
        conflict_count <= cnt;
        do @(posedge clk); while (!in_ready);
        sb.note_count(cnt);
        n_sent++;
        @(negedge clk);
        gap = ((n_sent / 60) % 4 == 3) ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_step(input logic [lrs_pkg::LRS_UNIT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_step(v);
    endtask

    // mostly counts just past the limit, some at or below it, some jumps
    function automatic logic [lrs_pkg::LRS_COUNT_W-1:0] pick_count();
        bit [63:0]   lim;
        bit [63:0]   r64;
        bit [63:0]   back;
        int unsigned sel;
        lim  = sb.threshold;
        r64  = {$urandom, $urandom};
        sel  = $urandom_range(0, 99);
        back = (lim < 64'd1000) ? lim : 64'd1000;
        if (sel < 55)
            return lrs_pkg::LRS_COUNT_W'(lim + 64'd1 + 64'($urandom_range(0, 15)));
        else if (sel < 70)
            return lrs_pkg::LRS_COUNT_W'(lim - (r64 % (back + 64'd1)));
        else if (sel < 80)
            return lrs_pkg::LRS_COUNT_W'(lim + 64'd1 + (r64 & 64'hF_FFFF));
        else if (sel < 92)
            return lrs_pkg::LRS_COUNT_W'(r64 % (lim + 64'd1));
        else
            return lrs_pkg::LRS_COUNT_W'(lim + 64'd1);
    endfunction

    initial
    begin
        logic [lrs_pkg::LRS_UNIT_W-1:0] steps [6];
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        conflict_count = '0;
        n_sent         = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset step size: zero count, first restart, limit boundary, below limit
        send_count('0);
        send_count(48'd1);
        send_count(48'(sb.threshold));
        send_count(48'(sb.threshold + 1));
        send_count(48'(sb.threshold + 1));
        send_count(48'd50);
        drain();

        // zero step: limit follows the count
        write_step('0);
        send_count(48'(sb.threshold + 1));
        send_count(48'(sb.threshold));
        send_count(48'(sb.threshold + 1));
        drain();

        write_step('1);
        send_count(48'(sb.threshold + 1));
        send_count(48'(sb.threshold));
        send_count(48'(sb.threshold + 1));
        send_count(48'(sb.threshold + 7));
        drain();

        write_step(16'd1);
        repeat (4) send_count(48'(sb.threshold + 1));
        drain();

        steps[0] = '1;
        steps[1] = 16'd1;
        steps[2] = '0;
        steps[3] = 16'($urandom_range(1, 65535));
        steps[4] = lrs_pkg::LRS_UNIT_RESET;
        steps[5] = 16'($urandom_range(2, 65534));
        foreach (steps[p])
        begin
            write_step(steps[p]);
            repeat (175) send_count(pick_count());
            drain();
        end

        // upper count bits, after which the limit stays out of reach
        send_count(48'h5555_5555_5555);
        send_count(48'hAAAA_AAAA_AAAA);
        send_count('1);
        send_count('0);
        send_count('1);
        drain();

        repeat (80) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS luby_restart_scheduler");
        else
            $display("FAIL luby_restart_scheduler");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/lrs_pkg.sv
hdl/lrs_luby_unit.sv
hdl/luby_restart_scheduler.sv
hdl/lrs_checker.sv
dv/tb.sv
